// ===== hw/rtl/rnr_pkg.sv =====
package rnr_pkg;

    localparam int ROW_W = 6;
    localparam int CHAR_W = 8;
    localparam int CNT_W = 6;
    localparam int ROWS = 45;

    localparam logic [ROW_W-1:0] START_ROW = 6'd38;
    localparam logic [ROW_W-1:0] ROW_REJ = 6'd45;
    localparam logic [ROW_W-1:0] ROW_ACC = 6'd46;
    localparam logic [ROW_W-1:0] ROW_LAST = 6'd44;
    localparam logic [CNT_W-1:0] WALK_LIMIT = 6'd63;

    localparam logic [CHAR_W-1:0] END_CODE = 8'd32;
    localparam logic [CHAR_W-1:0] CASE_OFFSET = 8'd32;

    localparam logic [1:0] VERDICT_PREFIX = 2'd0;
    localparam logic [1:0] VERDICT_ACCEPT = 2'd1;
    localparam logic [1:0] VERDICT_REJECT = 2'd2;

    localparam logic [CHAR_W-1:0] CH_NUL = 8'd0;
    localparam logic [CHAR_W-1:0] CH_I = "i";
    localparam logic [CHAR_W-1:0] CH_V = "v";
    localparam logic [CHAR_W-1:0] CH_X = "x";
    localparam logic [CHAR_W-1:0] CH_L = "l";
    localparam logic [CHAR_W-1:0] CH_C = "c";
    localparam logic [CHAR_W-1:0] CH_D = "d";
    localparam logic [CHAR_W-1:0] CH_M = "m";

    localparam logic [CHAR_W-1:0] ROW_WANT [ROWS] = '{
        CH_I, CH_NUL, CH_I, CH_NUL, CH_I, CH_V, CH_V, CH_NUL, CH_I, CH_NUL, CH_I, CH_X,
        CH_X, CH_NUL, CH_X, CH_NUL, CH_X, CH_L, CH_L, CH_NUL, CH_X, CH_NUL, CH_X, CH_C,
        CH_NUL,
        CH_C, CH_NUL, CH_C, CH_NUL, CH_C, CH_D, CH_D, CH_NUL, CH_C, CH_NUL, CH_C, CH_M,
        CH_NUL,
        CH_M, CH_NUL, CH_M, CH_NUL, CH_M, CH_NUL, CH_NUL
    };

    localparam logic [ROW_W-1:0] ROW_NEXT [ROWS] = '{
        6'd1, 6'd46, 6'd3, 6'd46, 6'd44, 6'd44, 6'd7, 6'd46, 6'd9, 6'd46, 6'd3, 6'd44,
        6'd13, 6'd46, 6'd15, 6'd46, 6'd24, 6'd24, 6'd19, 6'd46, 6'd21, 6'd46, 6'd15,
        6'd24, 6'd46,
        6'd26, 6'd46, 6'd28, 6'd46, 6'd37, 6'd37, 6'd32, 6'd46, 6'd34, 6'd46, 6'd28,
        6'd37, 6'd46,
        6'd39, 6'd46, 6'd41, 6'd46, 6'd43, 6'd46, 6'd46
    };

    localparam logic [ROW_W-1:0] ROW_FALL [ROWS] = '{
        6'd45, 6'd2, 6'd5, 6'd4, 6'd45, 6'd11, 6'd0, 6'd8, 6'd45, 6'd10, 6'd45, 6'd45,
        6'd6, 6'd14, 6'd17, 6'd16, 6'd24, 6'd23, 6'd12, 6'd20, 6'd24, 6'd22, 6'd24,
        6'd24, 6'd6,
        6'd18, 6'd27, 6'd30, 6'd29, 6'd37, 6'd36, 6'd25, 6'd33, 6'd37, 6'd35, 6'd37,
        6'd37, 6'd18,
        6'd31, 6'd40, 6'd31, 6'd42, 6'd43, 6'd31, 6'd45
    };

    typedef struct packed {
        logic              restart;
        logic [CHAR_W-1:0] char_code;
    } char_word_t;

    typedef struct packed {
        logic [1:0] verdict;
        logic       upper_case;
    } result_word_t;

    typedef struct packed {
        logic load;
        logic step;
        logic emit;
    } rnr_cmd_t;

    typedef struct packed {
        logic busy;
    } rnr_status_t;

    function automatic logic is_lower_roman(input logic [CHAR_W-1:0] c);
        return c == CH_I || c == CH_V || c == CH_X || c == CH_L ||
               c == CH_C || c == CH_D || c == CH_M;
    endfunction

    function automatic logic is_upper_roman(input logic [CHAR_W-1:0] c);
        return is_lower_roman(c + CASE_OFFSET);
    endfunction

endpackage

// ===== hw/rtl/roman_numeral_recognizer.sv =====
// Checks, one character word at a time, that a word is a well-formed Roman numeral from
// 1 to 3999 in a single case. Each character is loaded, then walks the fallback rows of
// the 45-row transition table until it settles, and then its result is emitted; the walk
// reads one row of the table per cycle. A restart word or a word that is settled at load
// skips the walk. A finished result waits in an output register, so the next character
// is taken while the previous result is still stalled.
module roman_numeral_recognizer (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  char_valid,
    output logic                  char_stall,
    input  rnr_pkg::char_word_t   char_word,
    output logic                  result_valid,
    input  logic                  result_stall,
    output rnr_pkg::result_word_t result_word
);
    import rnr_pkg::*;

    rnr_cmd_t    cmd;
    rnr_status_t status;

    rnr_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .char_valid   (char_valid),
        .char_stall   (char_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .status       (status),
        .cmd          (cmd)
    );

    rnr_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .char_word   (char_word),
        .cmd         (cmd),
        .status      (status),
        .result_word (result_word)
    );

endmodule

// ===== hw/rtl/rnr_ctrl.sv =====
module rnr_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 char_valid,
    output logic                 char_stall,
    output logic                 result_valid,
    input  logic                 result_stall,
    input  rnr_pkg::rnr_status_t status,
    output rnr_pkg::rnr_cmd_t    cmd
);
    import rnr_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_WALK
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || !result_stall;
    assign char_stall = (state_reg != ST_IDLE);
    assign result_valid = out_valid_reg;

    always_comb
    begin
        cmd = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (char_valid)
                begin
                    cmd.load = 1'b1;
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (status.busy)
                begin
                    cmd.step = 1'b1;
                end
                else if (out_free)
                begin
                    cmd.emit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== hw/rtl/rnr_datapath.sv =====
module rnr_datapath (
    input  logic                  clk,
    input  logic                  rst_n,
    input  rnr_pkg::char_word_t   char_word,
    input  rnr_pkg::rnr_cmd_t     cmd,
    output rnr_pkg::rnr_status_t  status,
    output rnr_pkg::result_word_t result_word
);
    import rnr_pkg::*;

    logic [ROW_W-1:0]  row_reg;
    logic [ROW_W-1:0]  row_next;
    logic              caps_reg;
    logic              caps_next;
    logic              active_reg;
    logic              active_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic [CHAR_W-1:0] key_reg;
    logic [CHAR_W-1:0] key_next;
    result_word_t      out_word_reg;
    logic [ROW_W-1:0]  row_idx;
    logic              at_start;
    logic              code_upper;
    logic              code_lower;
    logic [1:0]        verdict;

    assign row_idx = (row_reg <= ROW_LAST) ? row_reg : '0;
    assign at_start = (row_reg == START_ROW);
    assign code_upper = is_upper_roman(char_word.char_code);
    assign code_lower = is_lower_roman(char_word.char_code);
    assign status.busy = active_reg;
    assign result_word = out_word_reg;

    always_comb
    begin
        row_next = row_reg;
        caps_next = caps_reg;
        active_next = active_reg;
        cnt_next = cnt_reg;
        key_next = key_reg;
        if (cmd.load)
        begin
            cnt_next = '0;
            active_next = 1'b0;
            if (char_word.restart)
            begin
                row_next = START_ROW;
            end
            else if (row_reg > ROW_LAST)
            begin
                row_next = ROW_REJ;
            end
            else if (char_word.char_code <= END_CODE)
            begin
                key_next = CH_NUL;
                active_next = 1'b1;
            end
            else if (at_start && code_upper)
            begin
                caps_next = 1'b1;
                key_next = char_word.char_code + CASE_OFFSET;
                active_next = 1'b1;
            end
            else if (at_start && code_lower)
            begin
                caps_next = 1'b0;
                key_next = char_word.char_code;
                active_next = 1'b1;
            end
            else if (!at_start && caps_reg && code_upper)
            begin
                key_next = char_word.char_code + CASE_OFFSET;
                active_next = 1'b1;
            end
            else if (!at_start && !caps_reg && code_lower)
            begin
                key_next = char_word.char_code;
                active_next = 1'b1;
            end
            else
            begin
                row_next = ROW_REJ;
            end
        end
        else if (cmd.step && active_reg)
        begin
            if (row_reg > ROW_LAST)
            begin
                row_next = (row_reg == ROW_ACC) ? ROW_ACC : ROW_REJ;
                active_next = 1'b0;
            end
            else if (key_reg == ROW_WANT[row_idx])
            begin
                row_next = ROW_NEXT[row_idx];
                active_next = 1'b0;
            end
            else if (cnt_reg == WALK_LIMIT)
            begin
                row_next = ROW_REJ;
                active_next = 1'b0;
            end
            else
            begin
                row_next = ROW_FALL[row_idx];
                cnt_next = cnt_reg + 1'b1;
            end
        end
    end

    always_comb
    begin
        if (row_reg == ROW_ACC)
        begin
            verdict = VERDICT_ACCEPT;
        end
        else if (row_reg > ROW_LAST)
        begin
            verdict = VERDICT_REJECT;
        end
        else
        begin
            verdict = VERDICT_PREFIX;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= START_ROW;
            caps_reg <= 1'b0;
            active_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            row_reg <= row_next;
            caps_reg <= caps_next;
            active_reg <= active_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        if (cmd.emit)
        begin
            out_word_reg.verdict <= verdict;
            out_word_reg.upper_case <= caps_reg;
        end
    end

    a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        row_reg <= ROW_ACC)
        else $error("table row outside the table and the two end codes");

    a_emit_after_walk: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> !active_reg)
        else $error("result loaded while the fallback walk is still running");

    a_restart_row: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load && char_word.restart) |=> (row_reg == START_ROW && !active_reg))
        else $error("restart did not return to the start row");

endmodule
